// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the servo PWM design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, not checked while rst is high.
`define MSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define MSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Types, constants and helpers for the multi-channel servo PWM block.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  localparam int CHANNELS   = 8;
  localparam int RESOLUTION = 1000;

  // Fixed field widths
  localparam int REQ_TYPE_W = 2;
  localparam int CHANNEL_W  = 3;
  localparam int POSITION_W = 8;
  localparam int PIN_W      = 8;

  // Derived widths
  localparam int CNT_W  = $clog2(RESOLUTION);
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int USED_W = $clog2(CHANNELS + 1);

  // Pulse width mapping: ((pos * STEP) >> 8) + OFFSET
  localparam int STEP       = RESOLUTION / 10;
  localparam int OFFSET     = RESOLUTION / 40;
  localparam int STEP_W     = $clog2(STEP + 1);
  localparam int PROD_W     = POSITION_W + STEP_W;
  localparam int POS_CENTER = 128;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_ADD  = 2'd2,
    REQ_NOP  = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [CHANNEL_W-1:0]  channel;
    logic [POSITION_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [PIN_W-1:0]     pin_levels;
    logic [CHANNEL_W-1:0] new_channel;
    logic                 error;
  } rsp_t;

  function automatic logic [CNT_W-1:0] pos_to_compare(input logic [POSITION_W-1:0] pos);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] scaled;
    prod   = PROD_W'(pos) * PROD_W'(STEP);
    scaled = (prod >> 8) + PROD_W'(OFFSET);
    return scaled[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/msp_req_if.sv
// ----------------------------------------------------------------------------
// msp_req_if
// Request channel: valid/ready handshake with request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_req_if;
  import msp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [CHANNEL_W-1:0]  channel;
  logic [POSITION_W-1:0] position;

  modport source (output valid, output req_type, output channel, output position,
                  input ready);
  modport sink   (input valid, input req_type, input channel, input position,
                  output ready);
endinterface

`default_nettype wire

// File: design/msp_rsp_if.sv
// ----------------------------------------------------------------------------
// msp_rsp_if
// Result channel: valid/ready handshake with result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_rsp_if;
  import msp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIN_W-1:0]     pin_levels;
  logic [CHANNEL_W-1:0] new_channel;
  logic                 error;

  modport source (output valid, output pin_levels, output new_channel, output error,
                  input ready);
  modport sink   (input valid, input pin_levels, input new_channel, input error,
                  output ready);
endinterface

`default_nettype wire

// File: design/msp_engine.sv
// ----------------------------------------------------------------------------
// msp_engine
// Channel state (counter, compare table, levels) and per-item update logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msp_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire msp_pkg::req_t req,
  output msp_pkg::rsp_t      rsp
);
  import msp_pkg::*;

  logic [CNT_W-1:0]  period_count, period_count_next;
  logic [CNT_W-1:0]  compare_table [CHANNELS];
  logic [CNT_W-1:0]  compare_table_next [CHANNELS];
  logic [CHANNELS-1:0] levels, levels_next;
  logic [USED_W-1:0] channels_used, channels_used_next;

  logic [CHANNELS:0]       run;
  logic [CNT_W-1:0]        tick_count;
  logic [IDX_W+CHANNEL_W-1:0] chan_pad;
  logic [IDX_W-1:0]        chan_idx;
  logic [IDX_W-1:0]        used_idx;

  // leading run of nonzero compares marks active channels
  always_comb begin
    run[0] = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      run[i+1] = run[i] & (compare_table[i] != '0);
    end
  end

  assign tick_count = (period_count == CNT_W'(RESOLUTION - 1)) ? '0 : period_count + 1'b1;
  assign chan_pad   = {IDX_W'(0), req.channel};
  assign chan_idx   = chan_pad[IDX_W-1:0];
  assign used_idx   = channels_used[IDX_W-1:0];

  always_comb begin
    period_count_next  = period_count;
    compare_table_next = compare_table;
    levels_next        = levels;
    channels_used_next = channels_used;
    rsp.new_channel    = '0;
    rsp.error          = 1'b0;
    unique case (req.req_type)
      REQ_TICK: begin
        period_count_next = tick_count;
        for (int i = 0; i < CHANNELS; i++) begin
          if (run[i+1]) begin
            if (tick_count == '0) begin
              levels_next[i] = 1'b1;
            end else if (tick_count == compare_table[i]) begin
              levels_next[i] = 1'b0;
            end
          end
        end
      end
      REQ_SET: begin
        if (32'(req.channel) < CHANNELS) begin
          compare_table_next[chan_idx] = pos_to_compare(req.position);
        end else begin
          rsp.error = 1'b1;
        end
      end
      REQ_ADD: begin
        if (32'(channels_used) < CHANNELS) begin
          compare_table_next[used_idx] = pos_to_compare(POSITION_W'(POS_CENTER));
          levels_next[used_idx]        = 1'b0;
          rsp.new_channel              = CHANNEL_W'(channels_used);
          channels_used_next           = channels_used + 1'b1;
        end else begin
          rsp.error = 1'b1;
        end
      end
      REQ_NOP: begin
      end
      default: begin
      end
    endcase
    // only channels 0..7 are visible
    rsp.pin_levels = PIN_W'(levels_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count  <= '0;
      levels        <= '0;
      channels_used <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        compare_table[i] <= '0;
      end
    end else if (adv) begin
      period_count  <= period_count_next;
      levels        <= levels_next;
      channels_used <= channels_used_next;
      compare_table <= compare_table_next;
    end
  end

  `MSP_ASSERT(a_used_bound, 32'(channels_used) <= CHANNELS, "channels_used over limit")
  `MSP_ASSERT(a_cnt_bound, 32'(period_count) < RESOLUTION, "period_count over limit")
  `MSP_ASSERT(a_add_incr, adv && req.req_type == REQ_ADD && 32'(channels_used) < CHANNELS |=> channels_used == $past(channels_used) + 1'b1, "add did not claim channel")
  `MSP_ASSERT(a_tick_used, adv && req.req_type == REQ_TICK |=> $stable(channels_used), "tick changed channels_used")

endmodule

`default_nettype wire

// File: design/multi_channel_servo_pwm_top.sv
// Path: an accepted request goes through the input register, then the result register.
// Throughput: one item per cycle while the result is not stalled; each item is a single pass through the update logic.
// A stalled result holds the result register; the input register keeps taking one more item.
// Reset (rst, sync, active high): counter, compare table, levels and channel count cleared,
// both pipeline registers emptied.
// ----------------------------------------------------------------------------
// multi_channel_servo_pwm_top
// Servo pulse generator with tick, set-position and add-channel requests.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_servo_pwm_top (
  input  wire logic clk,
  input  wire logic rst,
  msp_req_if.sink   req,
  msp_rsp_if.source rsp
);
  import msp_pkg::*;

  // input register stage
  logic s1_valid;
  req_t s1_req;

  // result register stage
  logic out_valid;
  rsp_t out_rsp;

  rsp_t eng_rsp;
  logic adv;

  // item moves from input reg into state and result reg when result reg is free
  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // payload captured without reset
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req.req_type <= req_type_t'(req.req_type);
      s1_req.channel  <= req.channel;
      s1_req.position <= req.position;
    end
  end

  msp_engine u_engine (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (s1_req),
    .rsp (eng_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp <= eng_rsp;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pin_levels  = out_rsp.pin_levels;
  assign rsp.new_channel = out_rsp.new_channel;
  assign rsp.error       = out_rsp.error;

endmodule

`default_nettype wire
